// ===== src/tstx_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed serial byte transmitter package
// Shared types and constants for the 8N1 style transmit line.
// ----------------------------------------------------------------------------
package tstx_pkg;

   localparam int unsigned DATA_BITS = 8;

   localparam logic [7:0] BIT_TIME_RESET = 8'd104;
   localparam logic [3:0] PHASE_GUARD    = 4'd0;
   localparam logic [3:0] PHASE_START    = 4'd1;
   localparam logic [3:0] PHASE_LAST_DATA = 4'(DATA_BITS + 1);
   localparam logic [3:0] PHASE_STOP     = 4'(DATA_BITS + 2);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_SEND  = 2'd1,
      OP_IDLE  = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEQ_NONE  = 2'd0,
      SEQ_SEND  = 2'd1,
      SEQ_IDLE  = 2'd2,
      SEQ_CLOSE = 2'd3
   } seq_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic       burst_start;
   } item_type;

   typedef struct packed {
      logic tx_line;
      logic busy_res;
      logic accepted;
   } result_type;

endpackage

// ===== src/tstx_if.sv =====
// ----------------------------------------------------------------------------
// Timed serial byte transmitter channels
// Valid/ready channels for command transfers and result transfers.
// ----------------------------------------------------------------------------
interface tstx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic       burst_start;

   modport source (output valid, output operation, output data_byte,
                   output burst_start, input ready);
   modport sink (input valid, input operation, input data_byte,
                 input burst_start, output ready);
endinterface

interface tstx_rsp_if;
   logic valid;
   logic ready;
   logic tx_line;
   logic busy_res;
   logic accepted;

   modport source (output valid, output tx_line, output busy_res,
                   output accepted, input ready);
   modport sink (input valid, input tx_line, input busy_res,
                 input accepted, output ready);
endinterface

// ===== src/tstx_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Registers one command transfer and hands it to the core when the
// result side can take it.
// ----------------------------------------------------------------------------
module tstx_in_stage (
   input  logic              clock,
   input  logic              reset,
   tstx_req_if.sink          req,
   input  logic              advance,
   output logic              fire,
   output tstx_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   tstx_pkg::item_type item_ff;
   logic               take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign fire      = valid_ff && advance;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation   <= req.operation;
         item_ff.data_byte   <= req.data_byte;
         item_ff.burst_start <= req.burst_start;
      end
   end

endmodule

// ===== src/tstx_core.sv =====
// ----------------------------------------------------------------------------
// Transmit core
// Holds line state, bit timing and the bit time register; updates the line
// state and bit timing once per item and forms the item's result.
// ----------------------------------------------------------------------------
module tstx_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                fire,
   input  tstx_pkg::item_type  item,
   output tstx_pkg::result_type result
);

   logic [7:0]        bit_time_ff;
   logic              line_ff;
   logic              line_in;
   logic [3:0]        phase_ff;
   logic [3:0]        phase_in;
   logic [3:0]        phase_next;
   logic [7:0]        tick_ff;
   logic [7:0]        tick_in;
   logic [7:0]        tick_sat;
   logic [7:0]        shift_ff;
   logic [7:0]        shift_in;
   tstx_pkg::seq_type seq_ff;
   tstx_pkg::seq_type seq_in;
   tstx_pkg::op_type  op;
   logic [7:0]        bit_time;
   logic              taken;

   assign op         = tstx_pkg::op_type'(item.operation);
   assign bit_time   = (bit_time_ff == 8'd0) ? 8'd1 : bit_time_ff;
   assign tick_sat   = (tick_ff == 8'hFF) ? tick_ff : tick_ff + 8'd1;
   assign phase_next = phase_ff + 4'd1;

   always_comb begin
      line_in  = line_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      seq_in   = seq_ff;
      taken    = 1'b0;
      if (op == tstx_pkg::OP_TICK) begin
         if (seq_ff != tstx_pkg::SEQ_NONE) begin
            tick_in = tick_sat;
            if (tick_sat >= bit_time) begin
               // end of this level: advance to the next bit, or end the sequence
               tick_in = 8'd0;
               if (seq_ff != tstx_pkg::SEQ_SEND) begin
                  seq_in = tstx_pkg::SEQ_NONE;
               end else if (phase_ff >= tstx_pkg::PHASE_STOP) begin
                  seq_in   = tstx_pkg::SEQ_NONE;
                  phase_in = tstx_pkg::PHASE_GUARD;
                  line_in  = 1'b1;
               end else begin
                  phase_in = phase_next;
                  if (phase_next == tstx_pkg::PHASE_START) begin
                     line_in = 1'b0;
                  end else if (phase_next <= tstx_pkg::PHASE_LAST_DATA) begin
                     line_in  = shift_ff[0];
                     shift_in = {1'b0, shift_ff[7:1]};
                  end else begin
                     line_in = 1'b1;
                  end
               end
            end
         end
      end else if (seq_ff == tstx_pkg::SEQ_NONE) begin
         taken   = 1'b1;
         tick_in = 8'd0;
         case (op)
            tstx_pkg::OP_SEND: begin
               seq_in   = tstx_pkg::SEQ_SEND;
               shift_in = item.data_byte;
               if (item.burst_start) begin
                  phase_in = tstx_pkg::PHASE_GUARD;
                  line_in  = 1'b1;
               end else begin
                  phase_in = tstx_pkg::PHASE_START;
                  line_in  = 1'b0;
               end
            end
            tstx_pkg::OP_IDLE: begin
               seq_in   = tstx_pkg::SEQ_IDLE;
               phase_in = tstx_pkg::PHASE_GUARD;
               line_in  = 1'b1;
            end
            tstx_pkg::OP_CLOSE: begin
               seq_in   = tstx_pkg::SEQ_CLOSE;
               phase_in = tstx_pkg::PHASE_GUARD;
               line_in  = 1'b0;
            end
            default: begin
               taken = 1'b0;
            end
         endcase
      end
   end

   assign result.tx_line  = line_in;
   assign result.busy_res = (seq_in != tstx_pkg::SEQ_NONE);
   assign result.accepted = taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff <= tstx_pkg::BIT_TIME_RESET;
         line_ff     <= 1'b1;
         phase_ff    <= tstx_pkg::PHASE_GUARD;
         tick_ff     <= 8'd0;
         shift_ff    <= 8'd0;
         seq_ff      <= tstx_pkg::SEQ_NONE;
      end else begin
         if (csr_wr_en) begin
            bit_time_ff <= csr_wr_data;
         end
         if (fire) begin
            line_ff  <= line_in;
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            shift_ff <= shift_in;
            seq_ff   <= seq_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      fire && taken |=> seq_ff != tstx_pkg::SEQ_NONE)
      else $error("accepted command did not start a sequence");

   a_busy_rejects: assert property (@(posedge clock) disable iff (reset)
      fire && (op != tstx_pkg::OP_TICK) && (seq_ff != tstx_pkg::SEQ_NONE)
      |=> $stable(phase_ff) && $stable(tick_ff) && $stable(line_ff))
      else $error("rejected command changed line state");

   a_idle_tick_clear: assert property (@(posedge clock) disable iff (reset)
      seq_ff == tstx_pkg::SEQ_NONE |-> tick_ff == 8'd0)
      else $error("tick count left over while idle");

   a_phase_send_only: assert property (@(posedge clock) disable iff (reset)
      seq_ff != tstx_pkg::SEQ_SEND |-> phase_ff == tstx_pkg::PHASE_GUARD)
      else $error("bit phase moved outside a send");
`endif

endmodule

// ===== src/tstx_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Result register; holds a result until its transfer completes.
// ----------------------------------------------------------------------------
module tstx_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tstx_pkg::result_type result,
   output logic                 advance,
   tstx_rsp_if.source           rsp
);

   logic                 valid_ff;
   logic                 valid_in;
   tstx_pkg::result_type result_ff;

   assign advance      = !valid_ff || rsp.ready;
   assign rsp.valid    = valid_ff;
   assign rsp.tx_line  = result_ff.tx_line;
   assign rsp.busy_res = result_ff.busy_res;
   assign rsp.accepted = result_ff.accepted;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

endmodule

// ===== src/timed_serial_byte_transmitter_top.sv =====
// A command is registered in the input stage, then its result in the output stage.
// Throughput: one item per cycle; the input and result registers decouple
// the two channels, and a stalled result holds the stage behind it.
// Reset: synchronous, active high; line idles high, no sequence running,
// bit time returns to 104 ticks.
// ----------------------------------------------------------------------------
// Timed serial byte transmitter
// Transmit-only 8N1 serial line timed by tick items.
// ----------------------------------------------------------------------------
module timed_serial_byte_transmitter_top (
   input  logic       clock,
   input  logic       reset,
   tstx_req_if.sink   req,
   tstx_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                 fire;
   logic                 advance;
   tstx_pkg::item_type   item;
   tstx_pkg::result_type result;

   tstx_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .advance (advance),
      .fire    (fire),
      .item    (item)
   );

   tstx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .result      (result)
   );

   tstx_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .result  (result),
      .advance (advance),
      .rsp     (rsp)
   );

endmodule
